// ----- hw/rtl/nslf_pkg.sv -----
// shared types, codes and helpers for the node safety latch machine
`timescale 1ns / 1ps
`default_nettype none

package nslf_pkg;

    // event kinds carried in tuser
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_BEAT      = 3'd1;
    localparam logic [2:0] OP_ESTOP     = 3'd2;
    localparam logic [2:0] OP_CLEAR     = 3'd3;
    localparam logic [2:0] OP_COMMAND   = 3'd4;
    localparam logic [2:0] OP_MODE_REQ  = 3'd5;
    localparam logic [2:0] OP_BUS_DOWN  = 3'd6;

    // external mode encoding
    localparam logic [2:0] MODE_CODE_BOOT        = 3'd0;
    localparam logic [2:0] MODE_CODE_STANDBY     = 3'd1;
    localparam logic [2:0] MODE_CODE_OPERATIONAL = 3'd2;
    localparam logic [2:0] MODE_CODE_PASSIVE     = 3'd3;
    localparam logic [2:0] MODE_CODE_ESTOP       = 3'd4;
    localparam logic [2:0] MODE_CODE_FAULT       = 3'd5;

    // transition causes
    localparam logic [7:0] CAUSE_NONE      = 8'd0;
    localparam logic [7:0] CAUSE_OPERATOR  = 8'd1;
    localparam logic [7:0] CAUSE_SOFTWARE  = 8'd2;
    localparam logic [7:0] CAUSE_COMM_LOSS = 8'd3;

    // configuration register indexes
    localparam logic [2:0] REG_HB_TIMEOUT    = 3'd0;
    localparam logic [2:0] REG_STALE_TIME    = 3'd1;
    localparam logic [2:0] REG_ESTOP_REARM   = 3'd2;
    localparam logic [2:0] REG_PASSIVE_REARM = 3'd3;
    localparam logic [2:0] REG_CLEAR_KEY     = 3'd4;

    typedef enum logic [5:0] {
        MODE_BOOT        = 6'b000001,
        MODE_STANDBY     = 6'b000010,
        MODE_OPERATIONAL = 6'b000100,
        MODE_PASSIVE     = 6'b001000,
        MODE_ESTOP       = 6'b010000,
        MODE_FAULT       = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [23:0] hb_timeout;
        logic [23:0] stale_time;
        logic [23:0] estop_rearm;
        logic [23:0] passive_rearm;
        logic [31:0] clear_key;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now_time;
        logic [15:0] beat_sequence;
        logic        beat_latched;
        logic [7:0]  stop_cause;
        logic [31:0] clear_word;
        logic [31:0] clear_count;
        logic [2:0]  wanted_mode;
    } item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       changed;
        logic [2:0] prior_mode;
        logic [7:0] transition_cause;
        logic       clear_accepted;
        logic       command_fresh;
    } result_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] code;
        case (m)
            MODE_BOOT:        code = MODE_CODE_BOOT;
            MODE_STANDBY:     code = MODE_CODE_STANDBY;
            MODE_OPERATIONAL: code = MODE_CODE_OPERATIONAL;
            MODE_PASSIVE:     code = MODE_CODE_PASSIVE;
            MODE_ESTOP:       code = MODE_CODE_ESTOP;
            MODE_FAULT:       code = MODE_CODE_FAULT;
            default:          code = MODE_CODE_BOOT;
        endcase
        return code;
    endfunction

    // wrap-safe elapsed time, read as signed
    function automatic logic signed [31:0] elapsed(input logic [31:0] later,
                                                   input logic [31:0] earlier);
        return $signed(later - earlier);
    endfunction

    function automatic logic signed [31:0] widen24(input logic [23:0] v);
        return $signed({8'd0, v});
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nslf_cfg_regs.sv -----
// configuration register bank
`timescale 1ns / 1ps
`default_nettype none

module nslf_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [2:0]    wr_index,
    input  wire logic [31:0]   wr_data,
    output nslf_pkg::cfg_t     cfg
);
    import nslf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_HB_TIMEOUT:    cfg_next.hb_timeout    = wr_data[23:0];
                REG_STALE_TIME:    cfg_next.stale_time    = wr_data[23:0];
                REG_ESTOP_REARM:   cfg_next.estop_rearm   = wr_data[23:0];
                REG_PASSIVE_REARM: cfg_next.passive_rearm = wr_data[23:0];
                REG_CLEAR_KEY:     cfg_next.clear_key     = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hb_timeout    <= 24'd100;
            cfg_reg.stale_time    <= 24'd200;
            cfg_reg.estop_rearm   <= 24'd2000;
            cfg_reg.passive_rearm <= 24'd1000;
            cfg_reg.clear_key     <= 32'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nslf_engine.sv -----
// mode state, liveness tracking and per-event result logic
`timescale 1ns / 1ps
`default_nettype none

module nslf_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  nslf_pkg::item_t      item,
    input  nslf_pkg::cfg_t       cfg,
    output nslf_pkg::result_t    result
);
    import nslf_pkg::*;

    mode_t       mode_reg,        mode_next;
    logic [7:0]  cause_reg,       cause_next;
    logic [15:0] beat_seq_reg,    beat_seq_next;
    logic [31:0] beat_time_reg,   beat_time_next;
    logic [31:0] streak_reg,      streak_next;
    logic [31:0] cmd_time_reg,    cmd_time_next;
    logic        cmd_seen_reg,    cmd_seen_next;
    logic [31:0] clear_count_reg, clear_count_next;
    logic        beat_valid_reg,  beat_valid_next;
    logic        want_run_reg,    want_run_next;

    logic signed [31:0] beat_age;
    logic signed [31:0] streak_len;
    logic signed [31:0] cmd_age;
    logic signed [31:0] cmd_lead;
    logic signed [31:0] fresh_age;
    logic               link_ok;
    logic               beat_gap;
    logic               cmd_fresh_now;
    logic               cmd_in_streak;
    logic               estop_blocked;
    logic               estop_req;
    logic [7:0]         stop_code;
    logic               changed;
    logic [7:0]         ev_cause;
    logic               accepted;

    assign beat_age      = elapsed(item.now_time, beat_time_reg);
    assign streak_len    = beat_valid_reg ? elapsed(item.now_time, streak_reg) : 32'sd0;
    assign cmd_age       = elapsed(item.now_time, cmd_time_reg);
    assign cmd_lead      = elapsed(cmd_time_reg, streak_reg);
    assign link_ok       = beat_valid_reg && (beat_age <= widen24(cfg.hb_timeout));
    assign beat_gap      = beat_age > widen24(cfg.hb_timeout);
    assign cmd_fresh_now = cmd_seen_reg && (cmd_age < widen24(cfg.stale_time));
    // command must not predate the current streak
    assign cmd_in_streak = !cmd_lead[31];
    assign estop_blocked = (mode_reg == MODE_ESTOP) && (cause_reg != CAUSE_NONE);

    always_comb
    begin
        mode_next        = mode_reg;
        cause_next       = cause_reg;
        beat_seq_next    = beat_seq_reg;
        beat_time_next   = beat_time_reg;
        streak_next      = streak_reg;
        cmd_time_next    = cmd_time_reg;
        cmd_seen_next    = cmd_seen_reg;
        clear_count_next = clear_count_reg;
        beat_valid_next  = beat_valid_reg;
        want_run_next    = want_run_reg;
        changed          = 1'b0;
        ev_cause         = CAUSE_NONE;
        accepted         = 1'b0;
        estop_req        = 1'b0;
        stop_code        = CAUSE_OPERATOR;

        case (item.op)
            OP_TICK:
            begin
                case (mode_reg)
                    MODE_BOOT:
                    begin
                        mode_next = MODE_STANDBY;
                        changed   = 1'b1;
                    end
                    MODE_ESTOP:
                    begin
                        if (cause_reg == CAUSE_NONE && link_ok &&
                            streak_len >= widen24(cfg.estop_rearm))
                        begin
                            mode_next = MODE_STANDBY;
                            changed   = 1'b1;
                        end
                    end
                    MODE_OPERATIONAL:
                    begin
                        if (!link_ok)
                        begin
                            mode_next = MODE_PASSIVE;
                            changed   = 1'b1;
                            ev_cause  = CAUSE_COMM_LOSS;
                        end
                    end
                    MODE_STANDBY:
                    begin
                        if (want_run_reg && link_ok)
                        begin
                            mode_next = MODE_OPERATIONAL;
                            changed   = 1'b1;
                        end
                    end
                    MODE_PASSIVE:
                    begin
                        if (want_run_reg && link_ok &&
                            streak_len >= widen24(cfg.passive_rearm) &&
                            cmd_seen_reg && cmd_in_streak && cmd_fresh_now)
                        begin
                            mode_next = MODE_OPERATIONAL;
                            changed   = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            OP_BEAT:
            begin
                // duplicate sequence numbers are dropped, latch flag included
                if (!(beat_valid_reg && item.beat_sequence == beat_seq_reg))
                begin
                    if (!beat_valid_reg || beat_gap)
                    begin
                        streak_next = item.now_time;
                    end
                    beat_valid_next = 1'b1;
                    beat_time_next  = item.now_time;
                    beat_seq_next   = item.beat_sequence;
                    estop_req       = item.beat_latched;
                    stop_code       = CAUSE_OPERATOR;
                end
            end
            OP_ESTOP:
            begin
                estop_req = 1'b1;
                stop_code = (item.stop_cause != CAUSE_NONE) ? item.stop_cause
                                                            : CAUSE_SOFTWARE;
            end
            OP_CLEAR:
            begin
                if (item.clear_word == cfg.clear_key &&
                    item.clear_count > clear_count_reg)
                begin
                    accepted         = 1'b1;
                    clear_count_next = item.clear_count;
                    if (mode_reg == MODE_ESTOP)
                    begin
                        cause_next = CAUSE_NONE;
                    end
                end
            end
            OP_COMMAND:
            begin
                cmd_time_next = item.now_time;
                cmd_seen_next = 1'b1;
            end
            OP_MODE_REQ:
            begin
                case (item.wanted_mode)
                    MODE_CODE_OPERATIONAL:
                    begin
                        want_run_next = 1'b1;
                    end
                    MODE_CODE_STANDBY:
                    begin
                        want_run_next = 1'b0;
                        if (mode_reg == MODE_OPERATIONAL || mode_reg == MODE_PASSIVE)
                        begin
                            mode_next = MODE_STANDBY;
                            changed   = 1'b1;
                        end
                    end
                    MODE_CODE_PASSIVE:
                    begin
                        want_run_next = 1'b0;
                        if (mode_reg == MODE_OPERATIONAL || mode_reg == MODE_STANDBY)
                        begin
                            mode_next = MODE_PASSIVE;
                            changed   = 1'b1;
                        end
                    end
                    MODE_CODE_ESTOP:
                    begin
                        estop_req = 1'b1;
                        stop_code = CAUSE_OPERATOR;
                    end
                    default:
                    begin
                        want_run_next = want_run_reg;
                    end
                endcase
            end
            OP_BUS_DOWN:
            begin
                beat_valid_next = 1'b0;
                if (mode_reg == MODE_OPERATIONAL)
                begin
                    mode_next = MODE_PASSIVE;
                    changed   = 1'b1;
                    ev_cause  = CAUSE_COMM_LOSS;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // latching stop; a cleared stop relatches without a transition
        if (estop_req && !estop_blocked)
        begin
            cause_next    = stop_code;
            want_run_next = 1'b0;
            if (mode_reg != MODE_ESTOP)
            begin
                mode_next = MODE_ESTOP;
                changed   = 1'b1;
                ev_cause  = stop_code;
            end
        end
    end

    // freshness is judged on the state the event leaves behind
    assign fresh_age = elapsed(item.now_time, cmd_time_next);

    always_comb
    begin
        result.mode             = mode_code(mode_next);
        result.changed          = changed;
        result.prior_mode       = mode_code(mode_reg);
        result.transition_cause = changed ? ev_cause : CAUSE_NONE;
        result.clear_accepted   = accepted;
        result.command_fresh    = cmd_seen_next && (fresh_age < widen24(cfg.stale_time));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_BOOT;
            cause_reg       <= CAUSE_NONE;
            beat_seq_reg    <= 16'd0;
            beat_time_reg   <= 32'd0;
            streak_reg      <= 32'd0;
            cmd_time_reg    <= 32'd0;
            cmd_seen_reg    <= 1'b0;
            clear_count_reg <= 32'd0;
            beat_valid_reg  <= 1'b0;
            want_run_reg    <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg        <= mode_next;
            cause_reg       <= cause_next;
            beat_seq_reg    <= beat_seq_next;
            beat_time_reg   <= beat_time_next;
            streak_reg      <= streak_next;
            cmd_time_reg    <= cmd_time_next;
            cmd_seen_reg    <= cmd_seen_next;
            clear_count_reg <= clear_count_next;
            beat_valid_reg  <= beat_valid_next;
            want_run_reg    <= want_run_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/node_safety_latch_fsm.sv -----
// top level: input register, event engine, result register and config port
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser op, s_tdata event fields
// m_*       out  m_tvalid/m_tready  m_tdata result fields
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one event per clock sustained while m_tready stays high; a result follows its
// transaction through the input register and then the result register
// the whole event is resolved by one pass of logic on the mode state
// reset (rst_n low, asynchronous) returns to boot mode with default config
// a stalled result holds in the result register while the next event waits
// in the input register; s_tready drops only when both are full
`timescale 1ns / 1ps
`default_nettype none

module node_safety_latch_fsm (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output wire logic         s_tready,
    // now_time[31:0], beat_sequence[47:32], beat_latched[48], stop_cause[56:49],
    // clear_word[88:57], clear_count[120:89], wanted_mode[123:121], zero[127:124]
    input  wire logic [127:0] s_tdata,
    // op[2:0]
    input  wire logic [2:0]   s_tuser,
    output wire logic         m_tvalid,
    input  wire logic         m_tready,
    // mode[2:0], changed[3], prior_mode[6:4], transition_cause[14:7],
    // clear_accepted[15], command_fresh[16], zero[23:17]
    output wire logic [23:0]  m_tdata,
    input  wire logic         cfg_valid,
    output wire logic         cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import nslf_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t result;
    cfg_t    cfg;
    logic    advance;
    logic    s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    nslf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    nslf_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_reg.op            <= s_tuser;
            in_reg.now_time      <= s_tdata[31:0];
            in_reg.beat_sequence <= s_tdata[47:32];
            in_reg.beat_latched  <= s_tdata[48];
            in_reg.stop_cause    <= s_tdata[56:49];
            in_reg.clear_word    <= s_tdata[88:57];
            in_reg.clear_count   <= s_tdata[120:89];
            in_reg.wanted_mode   <= s_tdata[123:121];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.command_fresh, out_reg.clear_accepted,
                       out_reg.transition_cause, out_reg.prior_mode,
                       out_reg.changed, out_reg.mode};

    // a processed event always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed event did not produce a result");

    // a reported transition really changes the mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.changed) |-> (out_reg.mode != out_reg.prior_mode))
        else $error("transition reported without a mode change");

    // without a transition the prior mode is the mode and no cause is given
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_reg.changed) |->
            (out_reg.mode == out_reg.prior_mode &&
             out_reg.transition_cause == CAUSE_NONE))
        else $error("idle result carries transition data");

    // input register never overruns while the result side is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

endmodule

`default_nettype wire
